// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an overlapping implication under the block clock and reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check a non-overlapping implication under the block clock and reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/wsl_pkg.sv =====
package wsl_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_CAP     = (PATTERN_MAX < 32) ? PATTERN_MAX : 32;
    localparam int IDX_W       = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
    localparam int LEN_W       = 6;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 4;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_DATA_W  = 40;

    localparam logic [CHAR_W-1:0] CHAR_WILDCARD = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_NL       = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_WORD_0 = 3'd1,
        CFG_PATTERN_WORD_1 = 3'd2,
        CFG_PATTERN_WORD_2 = 3'd3,
        CFG_PATTERN_WORD_3 = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic advance;
        logic line_end;
    } cell_ctrl_t;

endpackage

// ===== src/wsl_cell.sv =====
module wsl_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wsl_pkg::cell_ctrl_t          ctrl,
    input  logic [wsl_pkg::CHAR_W-1:0]   text_char,
    input  logic [wsl_pkg::CHAR_W-1:0]   pattern_char,
    input  logic                         prev_hit,
    output logic                         hit_next,
    output logic                         hit
);
    import wsl_pkg::*;

    logic hit_reg;
    logic char_ok;

    assign char_ok  = (pattern_char == CHAR_WILDCARD) || (pattern_char == text_char);
    assign hit_next = prev_hit && char_ok;
    assign hit      = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            hit_reg <= ctrl.line_end ? 1'b0 : hit_next;
        end
    end

endmodule

// ===== src/wildcard_substring_line_matcher.sv =====
// Wildcard substring line matcher.
// Text bytes enter on the s_ channel, one per transaction; 0x0A or 0x00 ends a
// line. Each line end yields one transaction on the m_ channel carrying the
// match flag and the 1-based line number; other bytes yield nothing.
// The pattern is set on the cfg_ channel (index 0 length, 1..4 pattern words);
// the user must set it only while the block is idle; the block does not check.
// A pattern byte 0x2E matches any character. Matching runs in a row of cells,
// one per pattern position, each holding whether the pattern prefix ending at
// it matched the newest text byte. Throughput: one byte per cycle unless
// stalled. A line result appears on m_ in the cycle after its terminating byte
// is accepted. When the receiver stalls, the pending result holds in the
// output register and s_tready stays low until that result is taken; a result
// accepted in the same cycle as a new byte keeps the input flowing.
// Reset clears the pattern, the cell row and the match flag, and sets the
// line number to 1. cfg_ready is always high.
module wildcard_substring_line_matcher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] text_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wsl_pkg::OUT_DATA_W-1:0]       m_tdata,   // [0] line_matched,
                                                            // [32:1] line_index
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wsl_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wsl_pkg::WORD_W-1:0]           cfg_data
);
    import wsl_pkg::*;

    logic [LEN_W-1:0]                  pattern_length_reg;
    logic [NUM_WORDS-1:0][WORD_W-1:0]  pattern_words_reg;
    logic                              found_reg;
    logic                              found_next;
    logic [INDEX_W-1:0]                line_counter_reg;
    logic [INDEX_W-1:0]                line_counter_next;
    logic                              out_valid_reg;
    logic                              out_matched_reg;
    logic [INDEX_W-1:0]                out_index_reg;

    logic                              accept;
    logic                              line_end;
    logic [LEN_W-1:0]                  eff_len;
    logic [IDX_W-1:0]                  tap_idx;
    logic                              window_hit;
    logic                              line_hit;
    cell_ctrl_t                        ctrl;
    logic [LEN_CAP-1:0]                hit_next_vec;
    logic [LEN_CAP-1:0]                hit_vec;
    logic [NUM_WORDS*WORD_W-1:0]       pattern_flat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign line_end  = (s_tdata == CHAR_NL) || (s_tdata == CHAR_NUL);
    assign ctrl.advance  = accept;
    assign ctrl.line_end = line_end;
    assign pattern_flat  = pattern_words_reg;

    assign eff_len = (pattern_length_reg > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                            : pattern_length_reg;
    assign tap_idx = IDX_W'(eff_len - LEN_W'(1));

    genvar k;
    generate
        for (k = 0; k < LEN_CAP; k++)
        begin : g_cell
            wsl_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .text_char    (s_tdata),
                .pattern_char (pattern_flat[k*CHAR_W +: CHAR_W]),
                .prev_hit     ((k == 0) ? 1'b1 : hit_vec[(k == 0) ? 0 : k-1]),
                .hit_next     (hit_next_vec[k]),
                .hit          (hit_vec[k])
            );
        end
    endgenerate

    always_comb
    begin
        window_hit        = (eff_len != '0) && hit_next_vec[tap_idx];
        line_hit          = found_reg || (eff_len == '0);
        found_next        = line_end ? 1'b0 : (found_reg || window_hit);
        line_counter_next = (line_counter_reg == '1) ? INDEX_W'(1)
                                                     : line_counter_reg + INDEX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_words_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LENGTH: pattern_length_reg   <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_WORD_0: pattern_words_reg[0] <= cfg_data;
                CFG_PATTERN_WORD_1: pattern_words_reg[1] <= cfg_data;
                CFG_PATTERN_WORD_2: pattern_words_reg[2] <= cfg_data;
                CFG_PATTERN_WORD_3: pattern_words_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg        <= 1'b0;
            line_counter_reg <= INDEX_W'(1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                found_reg <= found_next;
            end
            if (accept && line_end)
            begin
                line_counter_reg <= line_counter_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && line_end)
        begin
            out_matched_reg <= line_hit;
            out_index_reg   <= line_counter_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - INDEX_W - 1)'(0), out_index_reg, out_matched_reg};

endmodule

// ===== src/wsl_checker.sv =====
`include "assert_macros.svh"

module wsl_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [7:0]                           s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [wsl_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import wsl_pkg::*;

    logic in_xact;
    logic in_end;
    logic out_free;

    assign in_xact  = s_tvalid && s_tready;
    assign in_end   = (s_tdata == CHAR_NL) || (s_tdata == CHAR_NUL);
    assign out_free = !m_tvalid || m_tready;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_NEXT(a_end_gives_result, clk, rst_n, in_xact && in_end, m_tvalid)
    `ASSERT_NEXT(a_char_no_result, clk, rst_n, in_xact && !in_end && out_free, !m_tvalid)
    `ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind wildcard_substring_line_matcher wsl_checker u_wsl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_wildcard_substring_line_matcher.sv =====
`timescale 1ns / 1ps

module tb_wildcard_substring_line_matcher;
    import wsl_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_BYTES    = 130;
    localparam int HOLD_LEN       = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int COUNT_SAT      = 63;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_UNUSED  = 3'd7;
    localparam logic [CHAR_W-1:0]      CHAR_A           = "a";

    typedef struct {
        logic               matched;
        logic [INDEX_W-1:0] index;
    } line_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data  = '0;

    logic [CHAR_W-1:0] pending_bytes[$];
    line_result_t      expected_lines[$];
    int unsigned       bytes_queued = 0;
    int unsigned       bytes_taken  = 0;

    logic [LEN_W-1:0]   mdl_len;
    logic [WORD_W-1:0]  mdl_words [NUM_WORDS];
    logic [CHAR_W-1:0]  mdl_recent [PATTERN_MAX];
    int unsigned        mdl_count;
    logic               mdl_found;
    logic [INDEX_W-1:0] mdl_line;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatch_cnt   = 0;
    line_result_t want;

    wildcard_substring_line_matcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned eff_pattern_len();
        return (mdl_len > LEN_CAP) ? LEN_CAP : mdl_len;
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_char(input int unsigned k);
        return mdl_words[k / 8][(k % 8) * CHAR_W +: CHAR_W];
    endfunction

    function automatic void advance_line_model(input logic [CHAR_W-1:0] b);
        int unsigned eff;
        logic        hit;
        eff = eff_pattern_len();
        if (b == CHAR_NL || b == CHAR_NUL)
        begin
            expected_lines.push_back('{matched: mdl_found || (eff == 0), index: mdl_line});
            mdl_line  = (mdl_line == '1) ? 1 : mdl_line + 1;
            mdl_count = 0;
            mdl_found = 1'b0;
        end
        else
        begin
            for (int i = PATTERN_MAX - 1; i > 0; i--)
                mdl_recent[i] = mdl_recent[i - 1];
            mdl_recent[0] = b;
            if (mdl_count < COUNT_SAT)
                mdl_count++;
            hit = (mdl_count >= eff);
            for (int k = 0; k < eff; k++)
                if (pattern_char(k) != CHAR_WILDCARD
                    && pattern_char(k) != mdl_recent[eff - 1 - k])
                    hit = 1'b0;
            if (hit)
                mdl_found = 1'b1;
        end
    endfunction

    function automatic void queue_byte(input logic [CHAR_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_text_char();
        case ($urandom_range(19))
            0:       return CHAR_W'($urandom_range(255));
            1:       return CHAR_WILDCARD;
            default: return CHAR_A + CHAR_W'($urandom_range(3));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] rand_pattern_char();
        if ($urandom_range(99) < 35)
            return CHAR_WILDCARD;
        return rand_text_char();
    endfunction

    task automatic queue_random_line();
        int unsigned n;
        int unsigned at;
        int unsigned cut;
        int unsigned kind;
        n    = ($urandom_range(9) == 0) ? $urandom_range(40, 75) : $urandom_range(0, 20);
        kind = $urandom_range(9);
        at   = $urandom_range(n);
        cut  = (kind < 5) ? eff_pattern_len() : $urandom_range(eff_pattern_len());
        for (int i = 0; i <= n; i++)
        begin
            if (i == at && kind < 7)
                for (int k = 0; k < cut; k++)
                    queue_byte((pattern_char(k) == CHAR_WILDCARD) ? rand_text_char()
                                                                  : pattern_char(k));
            if (i < n)
                queue_byte(rand_text_char());
        end
        queue_byte($urandom_range(1) ? CHAR_NL : CHAR_NUL);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PATTERN_LENGTH: mdl_len      = val[LEN_W-1:0];
            CFG_PATTERN_WORD_0: mdl_words[0] = val;
            CFG_PATTERN_WORD_1: mdl_words[1] = val;
            CFG_PATTERN_WORD_2: mdl_words[2] = val;
            CFG_PATTERN_WORD_3: mdl_words[3] = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || expected_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sender: advance to the next pending byte once the current transaction completes
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_line_model(s_tdata);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: hold off for a long stretch on request, else stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_LEN;
            m_tready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_lines.size() == 0)
            begin
                if (mismatch_cnt < MAX_REPORTS)
                    $display("unexpected line result: matched=%0b index=%0d",
                             m_tdata[0], m_tdata[INDEX_W:1]);
                mismatch_cnt++;
            end
            else
            begin
                want = expected_lines.pop_front();
                if (m_tdata[0] !== want.matched || m_tdata[INDEX_W:1] !== want.index)
                begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("expected matched=%0b index=%0d, actual matched=%0b index=%0d",
                                 want.matched, want.index, m_tdata[0], m_tdata[INDEX_W:1]);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [WORD_W-1:0] word;
        int unsigned       phase_start;

        mdl_len   = '0;
        mdl_count = 0;
        mdl_found = 1'b0;
        mdl_line  = 1;
        foreach (mdl_words[w])
            mdl_words[w] = '0;
        foreach (mdl_recent[i])
            mdl_recent[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern: every line matches, empty ones too
        queue_byte(CHAR_NL);
        queue_byte(CHAR_NUL);
        queue_byte(8'hFF);
        queue_byte(CHAR_NL);
        wait_drained();

        // wildcard in the middle; a dot in the text is literal
        write_reg(CFG_PATTERN_WORD_0, {40'h0, "c", CHAR_WILDCARD, CHAR_A});
        write_reg(CFG_PATTERN_LENGTH, WORD_W'(3));
        write_reg(CFG_LAST_UNUSED, 64'h1);
        queue_text("abc");
        queue_byte(CHAR_NL);
        queue_text(".bc");
        queue_byte(CHAR_NUL);
        wait_drained();

        // all-dot pattern needs a long enough line
        write_reg(CFG_PATTERN_WORD_0, {8{CHAR_WILDCARD}});
        queue_text("ab");
        queue_byte(CHAR_NL);
        queue_text("abc");
        queue_byte(CHAR_NL);
        wait_drained();

        // zero byte in the pattern never matches
        write_reg(CFG_PATTERN_WORD_0, {48'h0, CHAR_NUL, CHAR_A});
        write_reg(CFG_PATTERN_LENGTH, WORD_W'(2));
        queue_text("aa");
        queue_byte(CHAR_NL);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 54; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 54; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                if (p == RANDOM_PHASES - 1)
                    word = {$urandom, $urandom};
                else
                    for (int k = 0; k < 8; k++)
                        word[k * CHAR_W +: CHAR_W] = rand_pattern_char();
                write_reg(CFG_INDEX_W'(CFG_PATTERN_WORD_0 + w), word);
            end
            case (p)
                1:       write_reg(CFG_PATTERN_LENGTH, WORD_W'(LEN_CAP));
                4:       write_reg(CFG_PATTERN_LENGTH, WORD_W'({LEN_W{1'b1}}));
                7:       write_reg(CFG_PATTERN_LENGTH, WORD_W'(0));
                9:       write_reg(CFG_PATTERN_LENGTH, WORD_W'(40));
                default: write_reg(CFG_PATTERN_LENGTH, WORD_W'($urandom_range(1, 6)));
            endcase
            write_reg(CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                      {$urandom, $urandom});

            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES)
                queue_random_line();
            if (p == 0 || p == 6)
                hold_requests++;
            wait_drained();
        end

        if (mismatch_cnt == 0 && expected_lines.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/wsl_pkg.sv
src/wsl_cell.sv
src/wildcard_substring_line_matcher.sv
src/wsl_checker.sv
tb/sv/tb_wildcard_substring_line_matcher.sv
